// File: hdl/wdl_pkg.sv
package wdl_pkg;

    localparam int FRAME_W  = 26;
    localparam int SITE_LSB = 17;
    localparam int SITE_W   = 8;
    localparam int CARD_LSB = 1;
    localparam int CARD_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [4:0] FRAME_LEN = 5'd26;

    localparam logic [1:0] SERVO_OFF    = 2'd0;
    localparam logic [1:0] SERVO_UNLOCK = 2'd1;
    localparam logic [1:0] SERVO_LOCK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SITE_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_CODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_DELAY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST       = 3'd7;

    localparam logic [SITE_W-1:0] RST_SITE_CODE = 8'd11;
    localparam logic [CARD_W-1:0] RST_CARD_CODE = 16'd11111;
    localparam logic [CFG_W-1:0]  RST_UNLOCK_MS = 16'd1000;
    localparam logic [CFG_W-1:0]  RST_OPEN_WAIT = 16'd3000;
    localparam logic [CFG_W-1:0]  RST_DEBOUNCE  = 16'd100;
    localparam logic [CFG_W-1:0]  RST_LOCK_DELAY = 16'd1000;
    localparam logic [CFG_W-1:0]  RST_LOCK_MS   = 16'd1000;
    localparam logic [CFG_W-1:0]  RST_GHOST     = 16'd50;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_UNLOCK     = 3'd1,
        PH_OPEN_WAIT  = 3'd2,
        PH_CLOSE_DEB  = 3'd3,
        PH_LOCK_DELAY = 3'd4,
        PH_LOCK       = 3'd5,
        PH_OPEN_DEB   = 3'd6
    } t_phase;

    typedef struct packed {
        logic data_zero_pulse;
        logic data_one_pulse;
        logic release_pressed;
        logic door_closed;
        logic ms_tick;
    } t_in;

    typedef struct packed {
        logic [1:0] servo_command;
        logic       door_is_open_flag;
        logic       tag_accepted;
        logic       sequence_busy;
    } t_out;

    typedef struct packed {
        logic [1:0] servo_command;
        logic       door_is_open_flag;
        logic       sequence_busy;
    } t_seq_stat;

    typedef struct packed {
        logic [SITE_W-1:0] site_code;
        logic [CARD_W-1:0] card_code;
        logic [CFG_W-1:0]  unlock_drive_ms;
        logic [CFG_W-1:0]  open_wait_ms;
        logic [CFG_W-1:0]  debounce_ms;
        logic [CFG_W-1:0]  lock_delay_ms;
        logic [CFG_W-1:0]  lock_drive_ms;
        logic [CFG_W-1:0]  ghost_ms;
    } t_cfg;

endpackage

// File: hdl/wdl_wiegand.sv
module wdl_wiegand
    import wdl_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output logic o_match
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [FRAME_W-1:0]    r_frame, n_frame;
    logic [4:0]            r_count, n_count;
    logic [4:0]            r_last, n_last;
    logic [TIMER_BITS-1:0] r_ghost, n_ghost;
    logic [TIMER_BITS-1:0] ghost_inc;

    always_comb begin
        n_frame = r_frame;
        n_count = r_count;
        n_last  = r_last;
        n_ghost = r_ghost;
        o_match = 1'b0;
        ghost_inc = (r_ghost != '1) ? r_ghost + 1'b1 : r_ghost;

        if (i_item.data_zero_pulse || i_item.data_one_pulse) begin
            n_frame = {r_frame[FRAME_W-2:0], i_item.data_one_pulse};
            n_count = r_count + 5'd1;
        end
        if (n_count >= FRAME_LEN) begin
            o_match = (n_frame[SITE_LSB +: SITE_W] == i_cfg.site_code) &&
                      (n_frame[CARD_LSB +: CARD_W] == i_cfg.card_code);
            n_frame = '0;
            n_count = '0;
        end
        if (i_item.ms_tick) begin
            if (CMP_W'(ghost_inc) >= CMP_W'(i_cfg.ghost_ms)) begin
                n_ghost = '0;
                if (n_count < FRAME_LEN && n_count == r_last) begin
                    n_frame = '0;
                    n_count = '0;
                end
                n_last = n_count;
            end else begin
                n_ghost = ghost_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_count <= '0;
            r_last  <= '0;
            r_ghost <= '0;
        end else if (i_en) begin
            r_frame <= n_frame;
            r_count <= n_count;
            r_last  <= n_last;
            r_ghost <= n_ghost;
        end
    end

endmodule

// File: hdl/wdl_door_seq.sv
module wdl_door_seq
    import wdl_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in       i_item,
    input  t_cfg      i_cfg,
    input  logic      i_match,
    output t_seq_stat o_stat
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [TIMER_BITS-1:0] timer_inc;
    logic                  r_open, n_open;
    logic                  r_pending, n_pending;
    logic                  pending;
    logic [CFG_W-1:0]      limit;

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_open    = r_open;
        pending   = r_pending || i_match;
        n_pending = pending;
        limit     = i_cfg.debounce_ms;
        timer_inc = (i_item.ms_tick && r_timer != '1) ? r_timer + 1'b1 : r_timer;

        unique case (r_phase)
            PH_UNLOCK:     limit = i_cfg.unlock_drive_ms;
            PH_OPEN_WAIT:  limit = i_cfg.open_wait_ms;
            PH_CLOSE_DEB:  limit = i_cfg.debounce_ms;
            PH_LOCK_DELAY: limit = i_cfg.lock_delay_ms;
            PH_LOCK:       limit = i_cfg.lock_drive_ms;
            default:       limit = i_cfg.debounce_ms;
        endcase

        if (r_phase == PH_IDLE) begin
            if (i_item.release_pressed || pending) begin
                n_pending = 1'b0;
                n_phase   = PH_UNLOCK;
                n_timer   = '0;
            end else if (r_open && i_item.door_closed) begin
                n_phase = PH_CLOSE_DEB;
                n_timer = '0;
            end else if (!r_open && !i_item.door_closed) begin
                n_phase = PH_OPEN_DEB;
                n_timer = '0;
            end
        end else begin
            n_timer = timer_inc;
            if (CMP_W'(timer_inc) >= CMP_W'(limit)) begin
                n_timer = '0;
                unique case (r_phase)
                    PH_UNLOCK: n_phase = PH_OPEN_WAIT;
                    PH_OPEN_WAIT: begin
                        n_open  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                    PH_CLOSE_DEB: n_phase = i_item.door_closed ? PH_LOCK_DELAY : PH_IDLE;
                    PH_LOCK_DELAY: n_phase = PH_LOCK;
                    PH_LOCK: begin
                        n_open  = 1'b0;
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        if (!i_item.door_closed) begin
                            n_open = 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        o_stat.door_is_open_flag = n_open;
        o_stat.sequence_busy     = (n_phase != PH_IDLE);
        if (n_phase == PH_UNLOCK) begin
            o_stat.servo_command = SERVO_UNLOCK;
        end else if (n_phase == PH_LOCK) begin
            o_stat.servo_command = SERVO_LOCK;
        end else begin
            o_stat.servo_command = SERVO_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_open    <= 1'b1;
            r_pending <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_open    <= n_open;
            r_pending <= n_pending;
        end
    end

endmodule

// File: hdl/wiegand_door_lock_controller_core.sv
// An accepted item is held first in the input register, then in the result register.
// Throughput: one item per cycle; the input stage advances whenever the result
//   register is empty or being taken in the same cycle.
// Reset (synchronous, active low): both stages empty, frame and timers cleared,
//   sequencer idle, door assumed open, configuration back to its defaults.
module wiegand_door_lock_controller_core
    import wdl_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in       r_in;
    logic      r_out_valid;
    t_out      r_out;
    logic      advance;
    logic      match;
    t_seq_stat seq_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.site_code       <= RST_SITE_CODE;
            r_cfg.card_code       <= RST_CARD_CODE;
            r_cfg.unlock_drive_ms <= RST_UNLOCK_MS;
            r_cfg.open_wait_ms    <= RST_OPEN_WAIT;
            r_cfg.debounce_ms     <= RST_DEBOUNCE;
            r_cfg.lock_delay_ms   <= RST_LOCK_DELAY;
            r_cfg.lock_drive_ms   <= RST_LOCK_MS;
            r_cfg.ghost_ms        <= RST_GHOST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SITE_CODE:  r_cfg.site_code       <= i_cfg_wdata[SITE_W-1:0];
                CFG_CARD_CODE:  r_cfg.card_code       <= i_cfg_wdata;
                CFG_UNLOCK_MS:  r_cfg.unlock_drive_ms <= i_cfg_wdata;
                CFG_OPEN_WAIT:  r_cfg.open_wait_ms    <= i_cfg_wdata;
                CFG_DEBOUNCE:   r_cfg.debounce_ms     <= i_cfg_wdata;
                CFG_LOCK_DELAY: r_cfg.lock_delay_ms   <= i_cfg_wdata;
                CFG_LOCK_MS:    r_cfg.lock_drive_ms   <= i_cfg_wdata;
                CFG_GHOST:      r_cfg.ghost_ms        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.servo_command     <= seq_stat.servo_command;
            r_out.door_is_open_flag <= seq_stat.door_is_open_flag;
            r_out.tag_accepted      <= match;
            r_out.sequence_busy     <= seq_stat.sequence_busy;
        end
    end

    wdl_wiegand #(
        .TIMER_BITS(TIMER_BITS)
    ) u_wiegand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_match (match)
    );

    wdl_door_seq #(
        .TIMER_BITS(TIMER_BITS)
    ) u_door_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .i_match (match),
        .o_stat  (seq_stat)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without a full pipeline");

    a_servo_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.servo_command != SERVO_OFF |-> r_out.sequence_busy)
        else $error("servo driven while sequencer idle");

    a_servo_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.servo_command <= SERVO_LOCK)
        else $error("invalid servo command");

endmodule
